// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pointing offset rotate blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PORA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define PORA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pora_pkg.sv -----
// ----------------------------------------------------------------------------
// Pointing offset rotate package
// Widths, angle constants, arctangent table and payload types.
// ----------------------------------------------------------------------------
package pora_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES    = 32;
   localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   localparam int WORD_W = 32;            // Q16.16 offsets and positions, Q4.28 angles
   localparam int ANG_W  = 34;            // angle width during range reduction
   localparam int VEC_W  = 36;            // CORDIC vector datapath
   localparam int OFF_W  = 36;            // offset after gain removal
   localparam int DIFF_W = OFF_W + 1;     // offset after negation
   localparam int SUB_W  = DIFF_W + 1;    // position minus offset
   localparam int GAIN_W = 31;            // signed gain constant width
   localparam int GAIN_FRAC = 30;
   localparam int LO_W   = VEC_W / 2;     // low half of the split multiply
   localparam int PROD_W = LO_W + 1 + GAIN_W;
   localparam int SUM_W  = VEC_W + GAIN_W;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [OFF_W-1:0]  off_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [SUB_W-1:0]  sub_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam ang_type ANG_PI            = 34'sd843314857;
   localparam ang_type ANG_HALF_PI       = 34'sd421657428;
   localparam ang_type ANG_TWO_PI        = 34'sd1686629713;
   localparam ang_type ANG_FOUR_PI       = 34'sd3373259426;
   localparam ang_type ANG_SIX_PI        = 34'sd5059889139;
   localparam ang_type ANG_TWO_PI_M_HALF = 34'sd1264972285;
   localparam ang_type ANG_TWO_PI_M_PI   = 34'sd843314856;

   localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
   localparam sum_type GAIN_ROUND = sum_type'(1) <<< (GAIN_FRAC - 1);

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // atan(2^-i) in Q4.28, rounded to nearest.
   localparam word_type ATAN_TAB [MAX_STAGES] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32,
      32'sd16,        32'sd8,         32'sd4,        32'sd2,
      32'sd1,         32'sd0,         32'sd0,        32'sd0
   };

   // Fields of one time slice that ride along with the rotation.
   typedef struct packed {
      logic            is_azel;
      logic [WORD_W-1:0] offset_lon;
      logic [WORD_W-1:0] offset_lat;
      logic [WORD_W-1:0] azel_x;
      logic [WORD_W-1:0] azel_y;
      logic [WORD_W-1:0] track_x;
      logic [WORD_W-1:0] track_y;
      logic [3:0]      bad_mask;
   } pora_side_type;

   typedef struct packed {
      logic [WORD_W-1:0] azel_x;
      logic [WORD_W-1:0] azel_y;
      logic [WORD_W-1:0] track_x;
      logic [WORD_W-1:0] track_y;
      logic [3:0]      bad_mask;
   } pora_rsp_type;

endpackage

// ----- rtl/pointing_offset_rotate_apply_top.sv -----
// ----------------------------------------------------------------------------
// Pointing offset rotate and apply
// Rotates a pointing offset into the other frame and removes it from the
// jiggle positions of one time slice.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  is_azel, offsets, angles, positions, mask
// rsp_      out        rsp_valid / rsp_stall  corrected positions, mask
//
// One transfer per cycle is taken on req_ and given on rsp_ when nothing stalls.
// A slice passes NUM_STAGES + 6 register stages (22 with 16 CORDIC stages):
// three reduction stages, one stage per CORDIC micro-rotation, two gain stages
// and the output register, from which the slice shows on rsp_.
// Reset is synchronous and active high; it clears the valid bits only.
// A stall on rsp_ parks one result in a skid register; req_stall then rises
// in the following cycle, so the input side sees rsp_stall only through a register.
//
module pointing_offset_rotate_apply_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_is_azel,
   input  logic signed [31:0] req_offset_lon,
   input  logic signed [31:0] req_offset_lat,
   input  logic signed [31:0] req_azel_angle,
   input  logic signed [31:0] req_track_angle,
   input  logic signed [31:0] req_azel_x_in,
   input  logic signed [31:0] req_azel_y_in,
   input  logic signed [31:0] req_track_x_in,
   input  logic signed [31:0] req_track_y_in,
   input  logic [3:0]  req_bad_mask,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_azel_x_out,
   output logic signed [31:0] rsp_azel_y_out,
   output logic signed [31:0] rsp_track_x_out,
   output logic signed [31:0] rsp_track_y_out,
   output logic [3:0]  rsp_bad_mask_out
);

   // Global pipeline enable; it drops only while the skid register is full.
   logic advance;

   pora_pkg::pora_side_type req_side;

   logic                    red_valid;
   pora_pkg::word_type      red_z;
   pora_pkg::vec_type       red_x, red_y;
   pora_pkg::pora_side_type red_side;

   logic                    cor_valid;
   pora_pkg::vec_type       cor_x, cor_y;
   pora_pkg::pora_side_type cor_side;

   logic                    gain_valid;
   pora_pkg::off_type       gain_x, gain_y;
   pora_pkg::pora_side_type gain_side;

   pora_pkg::pora_rsp_type  rsp_data;

   // Everything that does not take part in the rotation rides along with it.
   always_comb begin
      req_side.is_azel    = req_is_azel;
      req_side.offset_lon = req_offset_lon;
      req_side.offset_lat = req_offset_lat;
      req_side.azel_x     = req_azel_x_in;
      req_side.azel_y     = req_azel_y_in;
      req_side.track_x    = req_track_x_in;
      req_side.track_y    = req_track_y_in;
      req_side.bad_mask   = req_bad_mask;
   end

   // A transfer is taken whenever the pipeline moves.
   assign req_stall = !advance;

   // The angle difference is reduced modulo two pi and folded into
   // [-pi/2, pi/2]; folding negates the offset vector.
   pora_angle_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .azel_angle  (req_azel_angle),
      .track_angle (req_track_angle),
      .in_side     (req_side),
      .out_valid   (red_valid),
      .out_z       (red_z),
      .out_x       (red_x),
      .out_y       (red_y),
      .out_side    (red_side)
   );

   // Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
   pora_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (red_valid),
      .in_z      (red_z),
      .in_x      (red_x),
      .in_y      (red_y),
      .in_side   (red_side),
      .out_valid (cor_valid),
      .out_x     (cor_x),
      .out_y     (cor_y),
      .out_side  (cor_side)
   );

   // The CORDIC gain is removed with a split multiply over two stages.
   pora_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (cor_valid),
      .in_x      (cor_x),
      .in_y      (cor_y),
      .in_side   (cor_side),
      .out_valid (gain_valid),
      .out_x     (gain_x),
      .out_y     (gain_y),
      .out_side  (gain_side)
   );

   // The offset of each frame is subtracted from its good positions, with
   // saturation, into the output register.
   pora_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gain_valid),
      .in_x      (gain_x),
      .in_y      (gain_y),
      .in_side   (gain_side),
      .advance   (advance),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_azel_x_out   = signed'(rsp_data.azel_x);
   assign rsp_azel_y_out   = signed'(rsp_data.azel_y);
   assign rsp_track_x_out  = signed'(rsp_data.track_x);
   assign rsp_track_y_out  = signed'(rsp_data.track_y);
   assign rsp_bad_mask_out = rsp_data.bad_mask;

endmodule

// ----- rtl/pora_angle_reduce.sv -----
// ----------------------------------------------------------------------------
// Angle reduction
// Three stages that bring the frame angle difference into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pora_angle_reduce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  pora_pkg::word_type      azel_angle,
   input  pora_pkg::word_type      track_angle,
   input  pora_pkg::pora_side_type in_side,
   output logic                    out_valid,
   output pora_pkg::word_type      out_z,
   output pora_pkg::vec_type       out_x,
   output pora_pkg::vec_type       out_y,
   output pora_pkg::pora_side_type out_side
);

   logic v1_ff, v2_ff, v3_ff;
   pora_pkg::ang_type diff, z1_in, z1_ff, z2_in, z2_ff, zr;
   pora_pkg::pora_side_type side1_ff, side2_ff, side3_ff;
   pora_pkg::word_type z3_ff;
   pora_pkg::vec_type lon_ext, lat_ext, x3_ff, y3_ff, x3_in, y3_in;
   logic neg;

   // Stage 1: a negative difference is lifted by three turns.
   assign diff  = pora_pkg::ang_type'(azel_angle) - pora_pkg::ang_type'(track_angle);
   assign z1_in = diff[pora_pkg::ANG_W-1] ? diff + pora_pkg::ANG_SIX_PI : diff;

   // Stage 2: remove whole turns to land in [0, 2pi).
   assign z2_in = (z1_ff >= pora_pkg::ANG_FOUR_PI) ? z1_ff - pora_pkg::ANG_FOUR_PI :
                  (z1_ff >= pora_pkg::ANG_TWO_PI)  ? z1_ff - pora_pkg::ANG_TWO_PI  : z1_ff;

   // Stage 3: center on zero and fold the outer quadrants by negating the vector.
   always_comb begin
      priority if (z2_ff <= pora_pkg::ANG_HALF_PI) begin
         zr  = z2_ff;
         neg = 1'b0;
      end else if (z2_ff < pora_pkg::ANG_PI) begin
         zr  = z2_ff - pora_pkg::ANG_PI;
         neg = 1'b1;
      end else if (z2_ff < pora_pkg::ANG_TWO_PI_M_HALF) begin
         zr  = z2_ff - pora_pkg::ANG_TWO_PI_M_PI;
         neg = 1'b1;
      end else begin
         zr  = z2_ff - pora_pkg::ANG_TWO_PI;
         neg = 1'b0;
      end
   end

   assign lon_ext = pora_pkg::vec_type'(signed'(side2_ff.offset_lon));
   assign lat_ext = pora_pkg::vec_type'(signed'(side2_ff.offset_lat));
   assign x3_in   = neg ? -lon_ext : lon_ext;
   assign y3_in   = neg ? -lat_ext : lat_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z1_ff    <= z1_in;
         side1_ff <= in_side;
         z2_ff    <= z2_in;
         side2_ff <= side1_ff;
         z3_ff    <= pora_pkg::word_type'(zr);
         x3_ff    <= x3_in;
         y3_ff    <= y3_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_z     = z3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_side  = side3_ff;

   `PORA_ASSERT(a_folded_angle, clock, reset, v3_ff |-> (pora_pkg::ang_type'(z3_ff) <= pora_pkg::ANG_HALF_PI && pora_pkg::ang_type'(z3_ff) >= -pora_pkg::ANG_HALF_PI), "folded angle outside half pi")

endmodule

// ----- rtl/pora_cordic.sv -----
// ----------------------------------------------------------------------------
// Rotation CORDIC
// One register stage per micro-rotation, rotation mode.
// ----------------------------------------------------------------------------
module pora_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  pora_pkg::word_type      in_z,
   input  pora_pkg::vec_type       in_x,
   input  pora_pkg::vec_type       in_y,
   input  pora_pkg::pora_side_type in_side,
   output logic                    out_valid,
   output pora_pkg::vec_type       out_x,
   output pora_pkg::vec_type       out_y,
   output pora_pkg::pora_side_type out_side
);

   logic [pora_pkg::NUM_STAGES-1:0] valid_ff;
   pora_pkg::vec_type       x_ff    [pora_pkg::NUM_STAGES];
   pora_pkg::vec_type       y_ff    [pora_pkg::NUM_STAGES];
   pora_pkg::word_type      z_ff    [pora_pkg::NUM_STAGES-1];
   pora_pkg::pora_side_type side_ff [pora_pkg::NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[pora_pkg::NUM_STAGES-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < pora_pkg::NUM_STAGES; i++) begin : g_stage
      pora_pkg::vec_type       x_cur, y_cur, x_in, y_in;
      pora_pkg::word_type      z_cur;
      pora_pkg::pora_side_type side_cur;

      if (i == 0) begin : g_head
         assign x_cur    = in_x;
         assign y_cur    = in_y;
         assign z_cur    = in_z;
         assign side_cur = in_side;
      end else begin : g_body
         assign x_cur    = x_ff[i-1];
         assign y_cur    = y_ff[i-1];
         assign z_cur    = z_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // A negative residual angle turns the vector clockwise.
      assign x_in = z_cur[pora_pkg::WORD_W-1] ? x_cur + (y_cur >>> i) : x_cur - (y_cur >>> i);
      assign y_in = z_cur[pora_pkg::WORD_W-1] ? y_cur - (x_cur >>> i) : y_cur + (x_cur >>> i);

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            side_ff[i] <= side_cur;
         end
      end

      if (i < pora_pkg::NUM_STAGES - 1) begin : g_angle
         pora_pkg::word_type z_in;

         assign z_in = z_cur[pora_pkg::WORD_W-1] ? z_cur + pora_pkg::ATAN_TAB[i]
                                                 : z_cur - pora_pkg::ATAN_TAB[i];

         always_ff @(posedge clock) begin
            if (advance) begin
               z_ff[i] <= z_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[pora_pkg::NUM_STAGES-1];
   assign out_x     = x_ff[pora_pkg::NUM_STAGES-1];
   assign out_y     = y_ff[pora_pkg::NUM_STAGES-1];
   assign out_side  = side_ff[pora_pkg::NUM_STAGES-1];

endmodule

// ----- rtl/pora_gain.sv -----
// ----------------------------------------------------------------------------
// CORDIC gain removal
// Split multiply by the inverse gain, then round half up and drop 30 bits.
// ----------------------------------------------------------------------------
module pora_gain (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  pora_pkg::vec_type       in_x,
   input  pora_pkg::vec_type       in_y,
   input  pora_pkg::pora_side_type in_side,
   output logic                    out_valid,
   output pora_pkg::off_type       out_x,
   output pora_pkg::off_type       out_y,
   output pora_pkg::pora_side_type out_side
);

   logic v1_ff, v2_ff;
   pora_pkg::prod_type xh_in, xl_in, yh_in, yl_in, xh_ff, xl_ff, yh_ff, yl_ff;
   pora_pkg::sum_type  x_sum, y_sum;
   pora_pkg::off_type  x2_ff, y2_ff;
   pora_pkg::pora_side_type side1_ff, side2_ff;

   // Stage 1: high half is signed, low half is zero-extended.
   always_comb begin
      xh_in = pora_pkg::prod_type'($signed(in_x[pora_pkg::VEC_W-1:pora_pkg::LO_W]))
              * pora_pkg::prod_type'(pora_pkg::GAIN_Q30);
      xl_in = pora_pkg::prod_type'($signed({1'b0, in_x[pora_pkg::LO_W-1:0]}))
              * pora_pkg::prod_type'(pora_pkg::GAIN_Q30);
      yh_in = pora_pkg::prod_type'($signed(in_y[pora_pkg::VEC_W-1:pora_pkg::LO_W]))
              * pora_pkg::prod_type'(pora_pkg::GAIN_Q30);
      yl_in = pora_pkg::prod_type'($signed({1'b0, in_y[pora_pkg::LO_W-1:0]}))
              * pora_pkg::prod_type'(pora_pkg::GAIN_Q30);
   end

   // Stage 2: recombine the partial products and round.
   assign x_sum = (pora_pkg::sum_type'(xh_ff) <<< pora_pkg::LO_W) + pora_pkg::sum_type'(xl_ff)
                  + pora_pkg::GAIN_ROUND;
   assign y_sum = (pora_pkg::sum_type'(yh_ff) <<< pora_pkg::LO_W) + pora_pkg::sum_type'(yl_ff)
                  + pora_pkg::GAIN_ROUND;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xh_ff    <= xh_in;
         xl_ff    <= xl_in;
         yh_ff    <= yh_in;
         yl_ff    <= yl_in;
         side1_ff <= in_side;
         x2_ff    <= x_sum[pora_pkg::GAIN_FRAC +: pora_pkg::OFF_W];
         y2_ff    <= y_sum[pora_pkg::GAIN_FRAC +: pora_pkg::OFF_W];
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_x     = x2_ff;
   assign out_y     = y2_ff;
   assign out_side  = side2_ff;

endmodule

// ----- rtl/pora_apply.sv -----
// ----------------------------------------------------------------------------
// Offset apply and output stage
// Saturating subtract per position, output register and skid register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pora_apply (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  pora_pkg::off_type       in_x,
   input  pora_pkg::off_type       in_y,
   input  pora_pkg::pora_side_type in_side,
   output logic                    advance,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output pora_pkg::pora_rsp_type  rsp_data
);

   function automatic pora_pkg::word_type apply_one(input pora_pkg::word_type pos,
                                                    input pora_pkg::diff_type off,
                                                    input logic bad);
      pora_pkg::sub_type d;
      d = pora_pkg::sub_type'(pos) - pora_pkg::sub_type'(off);
      priority if (bad) begin
         apply_one = pos;
      end else if (d > pora_pkg::sub_type'(pora_pkg::WORD_MAX)) begin
         apply_one = pora_pkg::WORD_MAX;
      end else if (d < pora_pkg::sub_type'(pora_pkg::WORD_MIN)) begin
         apply_one = pora_pkg::WORD_MIN;
      end else begin
         apply_one = pora_pkg::word_type'(d);
      end
   endfunction

   pora_pkg::diff_type other_lon, other_lat, own_lon, own_lat;
   pora_pkg::diff_type lon_az, lat_az, lon_tr, lat_tr;
   pora_pkg::pora_rsp_type push_data, out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in, push;

   // The rotated offset in the other frame is (-x, y).
   assign other_lon = -pora_pkg::diff_type'(in_x);
   assign other_lat = pora_pkg::diff_type'(in_y);
   assign own_lon   = pora_pkg::diff_type'(signed'(in_side.offset_lon));
   assign own_lat   = pora_pkg::diff_type'(signed'(in_side.offset_lat));
   assign lon_az    = in_side.is_azel ? own_lon : other_lon;
   assign lat_az    = in_side.is_azel ? own_lat : other_lat;
   assign lon_tr    = in_side.is_azel ? other_lon : own_lon;
   assign lat_tr    = in_side.is_azel ? other_lat : own_lat;

   always_comb begin
      push_data.azel_x   = apply_one(signed'(in_side.azel_x), lon_az, in_side.bad_mask[0]);
      push_data.azel_y   = apply_one(signed'(in_side.azel_y), lat_az, in_side.bad_mask[1]);
      push_data.track_x  = apply_one(signed'(in_side.track_x), lon_tr, in_side.bad_mask[2]);
      push_data.track_y  = apply_one(signed'(in_side.track_y), lat_tr, in_side.bad_mask[3]);
      push_data.bad_mask = in_side.bad_mask;
   end

   // The pipeline moves whenever the skid register is free.
   assign advance = !skid_valid_ff;
   assign push    = in_valid && advance;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `PORA_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid holds a result while output is empty")
   `PORA_ASSERT(a_stalled_push_parks, clock, reset, (out_valid_ff && rsp_stall && push) |=> (skid_valid_ff && $stable(out_ff)), "result pushed during stall was not parked")
   `PORA_ASSERT(a_skid_drains_first, clock, reset, (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && out_ff == $past(skid_ff)), "skid result not delivered next")

endmodule
